/* sv/yaz0_pkg.sv */
// ---------------------------------------------------------------------------
// yaz0 package
// shared types and constants for the yaz0 stream decompressor
// ---------------------------------------------------------------------------
`default_nettype none
package yaz0_pkg;
  localparam int HistDepth = 4096;
  localparam int HistAw = $clog2(HistDepth);
  localparam int BytesPerResult = 8;
  localparam int CntW = $clog2(BytesPerResult + 1);
  localparam int HeaderSize = 16;

  localparam logic [0:0] CfgMaxOutput = 1'b0;
  localparam logic [0:0] CfgSkipBytes = 1'b1;

  localparam logic [7:0] MagicY = 8'h59;
  localparam logic [7:0] Magica = 8'h61;
  localparam logic [7:0] Magicz = 8'h7a;
  localparam logic [7:0] Magic0 = 8'h30;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_DIST  = 2'd2,
    PH_EXT   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_COPY  = 3'd1,
    ST_WAIT  = 3'd2,
    ST_FLUSH = 3'd3,
    ST_HOLD  = 3'd4
  } state_t;

  // history port bundle
  typedef struct packed {
    logic              we;
    logic [HistAw-1:0] waddr;
    logic [7:0]        wdata;
    logic [HistAw-1:0] raddr;
  } hist_req_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0: m = MagicY;
      2'd1: m = Magica;
      2'd2: m = Magicz;
      default: m = Magic0;
    endcase
    return m;
  endfunction
endpackage
`default_nettype wire

/* sv/yaz0_hist_ram.sv */
// ---------------------------------------------------------------------------
// yaz0 history memory
// one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none
module yaz0_hist_ram (
  input  wire logic                 clk,
  input  wire yaz0_pkg::hist_req_t  req,
  output logic [7:0]                rdata
);
  import yaz0_pkg::*;
  logic [7:0] mem [HistDepth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

/* sv/yaz0_stream_decompressor_unit.sv */
// ---------------------------------------------------------------------------
// yaz0 stream decompressor
// parses the yaz0 header, decodes tokens and expands matches from history
// ---------------------------------------------------------------------------
// channel | direction | handshake      | payload
// in_     | input     | valid / stall  | in_byte, in_first_of_stream
// out_    | output    | valid / stall  | out_data, out_count, out_is_last, out_bad_header
// cfg_    | input     | valid / ready  | cfg_index, cfg_data
//
// header, code, match and length bytes are each taken while idle; a literal is
// produced, flushed, then waits for the output register to drain. a match of
// n bytes does one history read then one write per byte, then flushes and waits.
// every literal and match waits until its last result word has left the output
// register, and each produced byte pauses while eight bytes wait behind a stalled word.
// reset is synchronous and initialises all control state; history contents are
// undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none
module yaz0_stream_decompressor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_first_of_stream,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_data,
  output logic [3:0]       out_count,
  output logic             out_is_last,
  output logic             out_bad_header,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import yaz0_pkg::*;

  logic [31:0] max_r, skip_r;
  logic [4:0]  hidx_r, hidx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [3:0]  left_r, left_nxt;
  phase_t      ph_r, ph_nxt;
  logic [11:0] dist_r, dist_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [HistAw-1:0] hp_r, hp_nxt;
  logic [31:0] prod_r, prod_nxt, emit_r, emit_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  mlen_r, mlen_nxt;
  state_t      st_r, st_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [CntW-1:0] accn_r, accn_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] od_r, od_nxt;
  logic [3:0]  oc_r, oc_nxt;
  logic        ol_r, ol_nxt, ob_r, ob_nxt;
  logic        pend_last_r, pend_last_nxt;
  hist_req_t   hreq;
  logic [7:0]  hrd;
  logic        acc_in;
  logic [31:0] lim;
  logic        oslot;

  yaz0_hist_ram u_ram (.clk(clk), .req(hreq), .rdata(hrd));

  assign cfg_ready = 1'b1;
  // output register can take a new word when empty or being drained
  assign oslot    = !ov_r || !out_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;

  // output limit
  always_comb begin
    lim = (len_r > skip_r) ? len_r - skip_r : 32'd0;
    if (lim > max_r) lim = max_r;
  end

  // next state and datapath
  always_comb begin
    logic       do_prod;
    logic [7:0] pv;
    logic       cons;
    logic [7:0] b;
    hidx_nxt = hidx_r; len_nxt = len_r; code_nxt = code_r; left_nxt = left_r;
    ph_nxt = ph_r; dist_nxt = dist_r; nib_nxt = nib_r; hp_nxt = hp_r;
    prod_nxt = prod_r; emit_nxt = emit_r; done_nxt = done_r; mlen_nxt = mlen_r;
    st_nxt = st_r; acc_nxt = acc_r; accn_nxt = accn_r;
    ov_nxt = ov_r && out_stall; od_nxt = od_r; oc_nxt = oc_r; ol_nxt = ol_r;
    ob_nxt = ob_r; pend_last_nxt = pend_last_r;
    hreq = '0;
    hreq.raddr = hp_r - dist_r - 12'd1;
    do_prod = 1'b0; pv = in_byte; cons = 1'b0; b = in_byte;
    case (st_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (in_first_of_stream) begin
            hidx_nxt = '0; len_nxt = '0; code_nxt = '0; left_nxt = '0;
            ph_nxt = PH_CODE; dist_nxt = '0; nib_nxt = '0; hp_nxt = '0;
            prod_nxt = '0; emit_nxt = '0; done_nxt = 1'b0;
          end
          if (in_first_of_stream || !done_r) begin
            if ((in_first_of_stream ? 5'd0 : hidx_r) < 5'(HeaderSize)) begin
              logic [4:0] hi;
              logic [31:0] ln, l2;
              hi = in_first_of_stream ? 5'd0 : hidx_r;
              ln = in_first_of_stream ? 32'd0 : len_r;
              if (hi < 5'd4 && b != magic_byte(hi[1:0])) begin
                done_nxt = 1'b1; od_nxt = '0; oc_nxt = '0; ol_nxt = 1'b1; ob_nxt = 1'b1;
                ov_nxt = 1'b1; st_nxt = ST_WAIT;
              end else begin
                if (hi >= 5'd4 && hi < 5'd8) ln = {ln[23:0], b};
                len_nxt = ln;
                hidx_nxt = hi + 5'd1;
                l2 = (ln > skip_r) ? ln - skip_r : 32'd0;
                if (l2 > max_r) l2 = max_r;
                if (hi == 5'(HeaderSize - 1) && l2 == 32'd0) begin
                  done_nxt = 1'b1; od_nxt = '0; oc_nxt = '0; ol_nxt = 1'b1;
                  ob_nxt = 1'b0; ov_nxt = 1'b1; st_nxt = ST_WAIT;
                end
              end
            end else begin
              case (ph_r)
                PH_CODE: begin code_nxt = b; left_nxt = 4'd8; ph_nxt = PH_TOKEN; end
                PH_TOKEN: begin
                  if (code_r[7]) begin
                    do_prod = 1'b1; cons = 1'b1;
                  end else begin
                    nib_nxt = b[7:4]; dist_nxt = {b[3:0], 8'h00}; ph_nxt = PH_DIST;
                  end
                end
                PH_DIST: begin
                  dist_nxt = {dist_r[11:8], b};
                  if (nib_r == 4'd0) ph_nxt = PH_EXT;
                  else begin mlen_nxt = 9'(nib_r) + 9'd2; st_nxt = ST_COPY; end
                end
                default: begin mlen_nxt = 9'(b) + 9'h12; st_nxt = ST_COPY; end
              endcase
              if (!do_prod && st_nxt != ST_COPY) st_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_COPY: begin
        // read issued from current pointer
        if (done_r || mlen_r == 9'd0) begin
          cons = 1'b1; st_nxt = ST_FLUSH;
        end else st_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        pv = hrd; do_prod = 1'b1; mlen_nxt = mlen_r - 9'd1;
      end
      ST_WAIT: begin
        if (!ov_r || !out_stall) st_nxt = ST_IDLE;
      end
      default: begin
        // flush partial accumulator at end of item
        st_nxt = ST_WAIT;
      end
    endcase
    if (cons) begin
      code_nxt = {code_r[6:0], 1'b0};
      if (left_r > 4'd0) left_nxt = left_r - 4'd1;
      ph_nxt = (left_nxt == 4'd0) ? PH_CODE : PH_TOKEN;
    end
    // produce one byte; hold it while a full word waits behind a stalled one
    if (do_prod) begin
      if (accn_r == CntW'(BytesPerResult) && !oslot) begin
        mlen_nxt = mlen_r;
        do_prod = 1'b0;
      end
    end
    if (do_prod) begin
      logic [63:0] a; logic [CntW-1:0] n;
      a = acc_r; n = accn_r;
      hreq.we = 1'b1; hreq.waddr = hp_r; hreq.wdata = pv;
      hp_nxt = hp_r + HistAw'(1);
      if (prod_r >= skip_r) begin
        if (n == CntW'(BytesPerResult)) begin
          od_nxt = a; oc_nxt = 4'(n); ol_nxt = 1'b0; ob_nxt = 1'b0; ov_nxt = 1'b1;
          a = '0; n = '0;
        end
        a = a | (64'(pv) << (8 * n));
        n = n + CntW'(1);
        emit_nxt = emit_r + 32'd1;
        if (emit_nxt >= lim) begin
          pend_last_nxt = 1'b1; done_nxt = 1'b1;
        end
      end
      acc_nxt = a; accn_nxt = n;
      if (prod_r != 32'hFFFF_FFFF) prod_nxt = prod_r + 32'd1;
      if (st_r == ST_IDLE) st_nxt = ST_FLUSH;
      else st_nxt = ST_COPY;
    end
    // flush accumulator into output register
    if (st_r == ST_FLUSH) begin
      if (oslot) begin
        if (accn_r != '0) begin
          od_nxt = acc_r; oc_nxt = 4'(accn_r); ol_nxt = pend_last_r; ob_nxt = 1'b0;
          ov_nxt = 1'b1;
        end
        acc_nxt = '0; accn_nxt = '0; pend_last_nxt = 1'b0;
        st_nxt = ST_WAIT;
      end else st_nxt = ST_FLUSH;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 32'hFFFF_FFFF; skip_r <= '0; hidx_r <= '0; len_r <= '0; code_r <= '0;
      left_r <= '0; ph_r <= PH_CODE; dist_r <= '0; nib_r <= '0; hp_r <= '0;
      prod_r <= '0; emit_r <= '0; done_r <= 1'b1; mlen_r <= '0; st_r <= ST_IDLE;
      acc_r <= '0; accn_r <= '0; ov_r <= 1'b0; pend_last_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgMaxOutput) max_r <= cfg_data;
        else skip_r <= cfg_data;
      end
      hidx_r <= hidx_nxt; len_r <= len_nxt; code_r <= code_nxt; left_r <= left_nxt;
      ph_r <= ph_nxt; dist_r <= dist_nxt; nib_r <= nib_nxt; hp_r <= hp_nxt;
      prod_r <= prod_nxt; emit_r <= emit_nxt; done_r <= done_nxt; mlen_r <= mlen_nxt;
      st_r <= st_nxt; acc_r <= acc_nxt; accn_r <= accn_nxt; ov_r <= ov_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    od_r <= od_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt; ob_r <= ob_nxt;
  end

  assign out_valid      = ov_r;
  assign out_data       = od_r;
  assign out_count      = oc_r;
  assign out_is_last    = ol_r;
  assign out_bad_header = ob_r;
endmodule
`default_nettype wire

/* sv/yaz0_checker.sv */
// ---------------------------------------------------------------------------
// yaz0 port checker
// port-level properties of the decompressor
// ---------------------------------------------------------------------------
`default_nettype none
module yaz0_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_data,
  input wire logic [3:0]  out_count,
  input wire logic        out_is_last,
  input wire logic        out_bad_header
);
  // word count never exceeds eight
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= 4'd8) else $error("count above eight");
  // bad header word is empty and last
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_header |-> out_is_last && out_count == 4'd0)
    else $error("bad header word malformed");
  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled word changed");
  // non-last word carries bytes
  a_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> out_count != 4'd0) else $error("empty word");
endmodule

bind yaz0_stream_decompressor_unit yaz0_checker u_chk (.*);
`default_nettype wire
